// ----- design/bdq_pkg.sv -----
package bdq_pkg;

    localparam int CAPACITY = 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW       = $clog2(CAPACITY + 1);
    localparam int DW       = 32;
    localparam int CW       = 7;
    localparam int OPW      = 3;
    localparam int STW      = 2;
    localparam int TDATA_W  = ((DW + CW + 7) / 8) * 8;

    localparam logic [OPW-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OPW-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OPW-1:0] OP_ERASE      = 3'd2;
    localparam logic [OPW-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OPW-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OPW-1:0] OP_CLEAR      = 3'd5;
    localparam logic [OPW-1:0] OP_READ_FIRST = 3'd6;
    localparam logic [OPW-1:0] OP_READ_LAST  = 3'd7;

    localparam logic [STW-1:0] ST_OK    = 2'd0;
    localparam logic [STW-1:0] ST_FULL  = 2'd1;
    localparam logic [STW-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic simple;
        logic setup;
        logic rd_issue;
        logic rd_load;
        logic er_step;
        logic er_fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OPW-1:0] op;
        logic           empty;
        logic           n_zero;
        logic           out_free;
        logic           rd_last;
        logic           er_done;
    } t_sts;

    // physical slot of a logical position, wrapping around the ring
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [AW-1:0] logical);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, logical};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

endpackage

// ----- design/bounded_deque_with_value_erase.sv -----
// channel   dir  tdata (low bit up)             tuser          tlast
// s_axis    in   value[31:0], count[38:32]      operation[2:0] -
// m_axis    out  value_res[31:0], removed[38:32] status[1:0]   last
//
// push, clear and commands on an empty store: latched, decoded, then loaded into the output register
// pop and read of n entries: one ram read and load per beat, each load waiting for a free output register
// erase: one entry a cycle through the single ram port pair
// reset (i_rst_n low, synchronous) empties the store; ram contents are not cleared
// a new command is taken once the previous one has placed its last result in the
// output register; a stalled m_axis holds a read walk at its current entry
module bounded_deque_with_value_erase import bdq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // value, count
    input  logic [OPW-1:0]     s_axis_tuser,   // operation
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // value_res, removed
    output logic [STW-1:0]     m_axis_tuser,   // status
    output logic               m_axis_tlast
);

    t_cmd                 cmd;
    t_sts                 sts;
    logic signed [DW-1:0] value_res;
    logic [CW-1:0]        removed;

    bdq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_s_ready (s_axis_tready)
    );

    bdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (s_axis_tuser),
        .i_value     (s_axis_tdata[DW-1:0]),
        .i_count     (s_axis_tdata[DW+CW-1:DW]),
        .i_m_ready   (m_axis_tready),
        .o_sts       (sts),
        .o_m_valid   (m_axis_tvalid),
        .o_value_res (value_res),
        .o_last      (m_axis_tlast),
        .o_status    (m_axis_tuser),
        .o_removed   (removed)
    );

    assign m_axis_tdata = {{(TDATA_W-DW-CW){1'b0}}, removed, value_res};

`ifndef NO_ASSERTIONS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("controller issued more than one datapath command");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.simple || cmd.rd_load || cmd.er_fin) |-> sts.out_free)
        else $error("result loaded over an unread output beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again before the command was decoded");

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> cmd.load)
        else $error("accepted beat not latched");
`endif

endmodule

// ----- design/bdq_ram.sv -----
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/bdq_dp.sv -----
module bdq_dp import bdq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [OPW-1:0]        i_op,
    input  logic signed [DW-1:0]  i_value,
    input  logic [CW-1:0]         i_count,
    input  logic                  i_m_ready,
    output t_sts                  o_sts,
    output logic                  o_m_valid,
    output logic signed [DW-1:0]  o_value_res,
    output logic                  o_last,
    output logic [STW-1:0]        o_status,
    output logic [CW-1:0]         o_removed
);

    logic [OPW-1:0]       r_op;
    logic signed [DW-1:0] r_val;
    logic [CW-1:0]        r_cnt;
    logic [AW-1:0]        r_head;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        r_i;
    logic [LW-1:0]        r_w;
    logic [LW-1:0]        r_n;
    logic [LW-1:0]        r_start;
    logic                 r_pend;
    logic                 r_ovalid;
    logic signed [DW-1:0] r_o_value;
    logic                 r_o_last;
    logic [STW-1:0]       r_o_status;
    logic [CW-1:0]        r_o_removed;

    logic                 full;
    logic                 empty;
    logic                 is_pop;
    logic [CW-1:0]        n_req;
    logic [LW-1:0]        n_clamp;
    logic [LW-1:0]        rd_logical;
    logic                 rd_last;
    logic                 er_active;
    logic                 out_free;
    logic [AW-1:0]        head_dec;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [DW-1:0]        ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [DW-1:0]        ram_rd_data;

    assign full       = (r_len == LW'(CAPACITY));
    assign empty      = (r_len == '0);
    assign is_pop     = (r_op == OP_POP_FRONT) || (r_op == OP_POP_BACK);
    // count of zero with read first means the whole sequence
    assign n_req      = ((r_op == OP_READ_FIRST) && (r_cnt == '0)) ? CW'(r_len) : r_cnt;
    assign n_clamp    = (n_req > CW'(r_len)) ? r_len : LW'(n_req);
    assign rd_logical = r_start + r_i;
    assign rd_last    = ((r_i + LW'(1)) == r_n);
    assign er_active  = (r_i < r_len);
    assign out_free   = !r_ovalid || i_m_ready;
    assign head_dec   = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);

    assign o_sts.op       = r_op;
    assign o_sts.empty    = empty;
    assign o_sts.n_zero   = (n_clamp == '0);
    assign o_sts.out_free = out_free;
    assign o_sts.rd_last  = rd_last;
    assign o_sts.er_done  = !r_pend && !er_active;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot(r_head, r_w[AW-1:0]);
        ram_wr_data = r_val;
        ram_rd_en   = 1'b0;
        ram_rd_addr = slot(r_head, rd_logical[AW-1:0]);
        if (i_cmd.simple && !full) begin
            if (r_op == OP_PUSH_BACK) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = slot(r_head, r_len[AW-1:0]);
            end else if (r_op == OP_PUSH_FRONT) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = head_dec;
            end
        end
        if (i_cmd.rd_issue) begin
            ram_rd_en = 1'b1;
        end
        // compaction: read ahead at r_i, write back survivors at r_w
        if (i_cmd.er_step) begin
            ram_rd_en   = er_active;
            ram_rd_addr = slot(r_head, r_i[AW-1:0]);
            ram_wr_en   = r_pend && (ram_rd_data != r_val);
            ram_wr_data = ram_rd_data;
        end
    end

    bdq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_len    <= '0;
            r_i      <= '0;
            r_w      <= '0;
            r_n      <= '0;
            r_start  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.simple || i_cmd.rd_load || i_cmd.er_fin) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.simple) begin
                case (r_op)
                    OP_PUSH_BACK: begin
                        if (!full) begin
                            r_len <= r_len + LW'(1);
                        end
                    end
                    OP_PUSH_FRONT: begin
                        if (!full) begin
                            r_head <= head_dec;
                            r_len  <= r_len + LW'(1);
                        end
                    end
                    OP_CLEAR: begin
                        r_head <= '0;
                        r_len  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.setup) begin
                r_i    <= '0;
                r_w    <= '0;
                r_pend <= 1'b0;
                r_n    <= is_pop ? LW'(1) : n_clamp;
                if (r_op == OP_POP_BACK) begin
                    r_start <= r_len - LW'(1);
                end else if (r_op == OP_READ_LAST) begin
                    r_start <= r_len - n_clamp;
                end else begin
                    r_start <= '0;
                end
            end
            if (i_cmd.rd_load) begin
                r_i      <= r_i + LW'(1);
                if (is_pop) begin
                    r_len <= r_len - LW'(1);
                end
                if (r_op == OP_POP_FRONT) begin
                    r_head <= slot(r_head, AW'(1));
                end
            end
            if (i_cmd.er_step) begin
                r_pend <= er_active;
                if (er_active) begin
                    r_i <= r_i + LW'(1);
                end
                if (ram_wr_en) begin
                    r_w <= r_w + LW'(1);
                end
            end
            if (i_cmd.er_fin) begin
                r_len    <= r_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_val <= i_value;
            r_cnt <= i_count;
        end
        if (i_cmd.simple) begin
            r_o_value   <= '0;
            r_o_last    <= 1'b1;
            r_o_removed <= '0;
            case (r_op)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    r_o_status <= full ? ST_FULL : ST_OK;
                end
                OP_CLEAR: begin
                    r_o_status  <= ST_OK;
                    r_o_removed <= CW'(r_len);
                end
                default: begin
                    r_o_status <= empty ? ST_EMPTY : ST_OK;
                end
            endcase
        end
        if (i_cmd.rd_load) begin
            r_o_value   <= ram_rd_data;
            r_o_last    <= rd_last;
            r_o_status  <= ST_OK;
            r_o_removed <= is_pop ? CW'(1) : '0;
        end
        if (i_cmd.er_fin) begin
            r_o_value   <= '0;
            r_o_last    <= 1'b1;
            r_o_status  <= ST_OK;
            r_o_removed <= CW'(r_len - r_w);
        end
    end

    assign o_m_valid   = r_ovalid;
    assign o_value_res = r_o_value;
    assign o_last      = r_o_last;
    assign o_status    = r_o_status;
    assign o_removed   = r_o_removed;

endmodule

// ----- design/bdq_ctrl.sv -----
module bdq_ctrl import bdq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_s_ready
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_RD_ISSUE = 3'd2;
    localparam logic [2:0] S_RD_LOAD  = 3'd3;
    localparam logic [2:0] S_ERASE    = 3'd4;
    localparam logic [2:0] S_ER_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_PUSH_BACK, OP_PUSH_FRONT, OP_CLEAR: begin
                        if (i_sts.out_free) begin
                            o_cmd.simple = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_ERASE: begin
                        if (!i_sts.empty) begin
                            o_cmd.setup = 1'b1;
                            n_state     = S_ERASE;
                        end else if (i_sts.out_free) begin
                            o_cmd.simple = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (!i_sts.empty) begin
                            o_cmd.setup = 1'b1;
                            n_state     = S_RD_ISSUE;
                        end else if (i_sts.out_free) begin
                            o_cmd.simple = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        // read first or read last
                        if (!i_sts.empty && !i_sts.n_zero) begin
                            o_cmd.setup = 1'b1;
                            n_state     = S_RD_ISSUE;
                        end else if (i_sts.out_free) begin
                            o_cmd.simple = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_LOAD;
            end
            S_RD_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.rd_load = 1'b1;
                    n_state       = i_sts.rd_last ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_ERASE: begin
                if (i_sts.er_done) begin
                    n_state = S_ER_FIN;
                end else begin
                    o_cmd.er_step = 1'b1;
                end
            end
            S_ER_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.er_fin = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);

endmodule
